// ----- design/mre_pkg.sv -----
// Shared types and constants for the multi-reader event ring.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package mre_pkg;

    localparam int PARTS   = 4;
    localparam int SUBS    = 8;
    localparam int MAX_CAP = 256;
    localparam int CAP_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int PART_W  = 2;
    localparam int SUB_W   = 3;
    localparam int TYPE_W  = 8;
    localparam int DATA_W  = 32;
    localparam int ID_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] CMD_PUBLISH   = 2'd0;
    localparam logic [1:0] CMD_SUBSCRIBE = 2'd1;
    localparam logic [1:0] CMD_CONSUME   = 2'd2;
    localparam logic [1:0] CMD_REWIND    = 2'd3;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_PART     = 4'd1;
    localparam logic [3:0] ST_NO_SUB      = 4'd2;
    localparam logic [3:0] ST_NOT_SUBSCR  = 4'd3;
    localparam logic [3:0] ST_BAD_STEPS   = 4'd4;
    localparam logic [3:0] ST_NEG_TARGET  = 4'd5;
    localparam logic [3:0] ST_OVERWRITTEN = 4'd6;
    localparam logic [3:0] ST_NO_MATCH    = 4'd7;
    localparam logic [3:0] ST_IDS_DONE    = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_PART_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP3    = 3'd5;

    typedef struct packed {
        logic [1:0]        command;
        logic [PART_W-1:0] partition_index;
        logic [SUB_W-1:0]  subscriber_index;
        logic [TYPE_W-1:0] event_kind;
        logic              match_any;
        logic [DATA_W-1:0] payload_in;
        logic [15:0]       rewind_steps;
    } request_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [ID_W-1:0]   event_id;
        logic [TYPE_W-1:0] event_kind_out;
        logic [DATA_W-1:0] payload_out;
        logic              overrun;
        logic [ID_W-1:0]   read_pointer;
    } result_t;

    // A request after the front end has checked partition and subscriber.
    typedef struct packed {
        request_t   req;
        logic       err;
        logic [3:0] err_code;
    } op_t;

    typedef logic [PARTS-1:0][CAP_W-1:0] cap_vec_t;

endpackage

// ----- design/mre_front.sv -----
// Front end: accepts requests, checks partition and subscriber enables,
// and queues the classified operations for the back end. Uses mre_pkg.
`timescale 1ns / 1ps
module mre_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  mre_pkg::request_t          request,
    input  logic [mre_pkg::PARTS-1:0]  part_en,
    input  logic [mre_pkg::SUBS-1:0]   sub_en,
    output mre_pkg::op_t               op,
    output logic                       op_valid,
    input  logic                       op_pop
);
    import mre_pkg::*;

    op_t        q_mem [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    op_t        cls;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        cls.req      = request;
        cls.err      = 1'b0;
        cls.err_code = ST_OK;
        if (!part_en[request.partition_index])
        begin
            cls.err      = 1'b1;
            cls.err_code = ST_NO_PART;
        end
        else if (request.command != CMD_PUBLISH && !sub_en[request.subscriber_index])
        begin
            cls.err      = 1'b1;
            cls.err_code = ST_NO_SUB;
        end
    end

    assign full     = (cnt_reg == 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_mem[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = op_pop && op_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- design/mre_back.sv -----
// Back end: holds ids, subscriber pointers, filters and the event memory,
// and carries out one operation at a time. Uses mre_pkg.
`timescale 1ns / 1ps
module mre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mre_pkg::op_t      op,
    input  logic              op_valid,
    output logic              op_pop,
    input  mre_pkg::cap_vec_t cap,
    input  logic              res_full,
    output logic              res_push,
    output mre_pkg::result_t  res
);
    import mre_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    localparam int MEM_DEPTH = PARTS * MAX_CAP;
    localparam int SI_W      = PART_W + SUB_W;

    logic [TYPE_W+DATA_W-1:0] mem [MEM_DEPTH];
    logic [TYPE_W+DATA_W-1:0] rd_reg;

    logic [ID_W-1:0]     next_id_reg [PARTS];
    logic [ID_W-1:0]     ptr_reg [PARTS*SUBS];
    logic [TYPE_W+1:0]   filt_reg [PARTS*SUBS];
    logic [SLOT_W-1:0]   wslot_reg [PARTS];
    logic [CAP_W-1:0]    ccap_reg [PARTS];
    logic [PARTS-1:0]    cok_reg;

    logic [2:0]          state_reg;
    op_t                 op_reg;
    logic [ID_W-1:0]     cur_reg;
    logic                over_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CAP_W:0]      rem_reg;
    logic [4:0]          cnt_reg;
    logic                push_reg;
    result_t             res_reg;

    logic [PART_W-1:0]   p;
    logic [SI_W-1:0]     si;
    logic [CAP_W-1:0]    cap_c;
    logic [ID_W-1:0]     nid;
    logic [ID_W-1:0]     old;
    logic                cache_hit;
    logic [ID_W-1:0]     cur_ptr;
    logic [TYPE_W+1:0]   filt;
    logic [ID_W-1:0]     gap_full;
    logic [CAP_W-1:0]    gap;
    logic [CAP_W-1:0]    wslot_c;
    logic [CAP_W-1:0]    slot_calc;
    logic [CAP_W:0]      rem_sh;
    logic [CAP_W:0]      rem_nx;
    logic [ID_W-1:0]     cur_inc;
    logic [CAP_W-1:0]    slot_inc;
    logic [CAP_W-1:0]    wslot_inc;
    logic                match;
    logic                mem_we;
    logic [ID_W-1:0]     rw_target;

    assign p         = op_reg.req.partition_index;
    assign si        = {op_reg.req.partition_index, op_reg.req.subscriber_index};
    assign cap_c     = cap[p];
    assign nid       = next_id_reg[p];
    assign old       = (nid > {{(ID_W-CAP_W){1'b0}}, cap_c})
                       ? nid - {{(ID_W-CAP_W){1'b0}}, cap_c} : '0;
    assign cache_hit = cok_reg[p] && (ccap_reg[p] == cap_c);
    assign cur_ptr   = ptr_reg[si];
    assign filt      = filt_reg[si];
    assign rw_target = cur_ptr - {16'd0, op_reg.req.rewind_steps};

    // The write slot tracks next_id mod capacity, so a stored id's slot is
    // found by stepping back from it; the distance never exceeds capacity.
    assign gap_full  = nid - cur_reg;
    assign gap       = gap_full[CAP_W-1:0];
    assign wslot_c   = {1'b0, wslot_reg[p]};
    assign slot_calc = (wslot_c >= gap) ? wslot_c - gap : wslot_c + cap_c - gap;

    assign rem_sh = {rem_reg[CAP_W-1:0], nid[cnt_reg]};
    assign rem_nx = (rem_sh >= {1'b0, cap_c}) ? rem_sh - {1'b0, cap_c} : rem_sh;

    assign cur_inc   = cur_reg + 1'b1;
    assign slot_inc  = ({1'b0, slot_reg} + 1'b1 == cap_c) ? '0 : {1'b0, slot_reg} + 1'b1;
    assign wslot_inc = (wslot_c + 1'b1 == cap_c) ? '0 : wslot_c + 1'b1;

    assign match = filt[TYPE_W] || (rd_reg[TYPE_W+DATA_W-1:DATA_W] == filt[TYPE_W-1:0]);

    assign op_pop   = (state_reg == S_IDLE) && op_valid && !res_full && !push_reg;
    assign res_push = push_reg;
    assign res      = res_reg;

    assign mem_we = (state_reg == S_EXEC) && !op_reg.err
                    && (op_reg.req.command == CMD_PUBLISH)
                    && (nid != '1) && cache_hit;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[{p, wslot_reg[p]}] <= {op_reg.req.event_kind, op_reg.req.payload_in};
        end
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[{p, slot_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            push_reg  <= 1'b0;
            cok_reg   <= '0;
            for (int i = 0; i < PARTS; i++)
            begin
                next_id_reg[i] <= '0;
                wslot_reg[i]   <= '0;
                ccap_reg[i]    <= '0;
            end
            for (int i = 0; i < PARTS*SUBS; i++)
            begin
                ptr_reg[i]  <= '0;
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            push_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_pop)
                    begin
                        op_reg    <= op;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg   <= '0;
                    push_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (op_reg.err)
                    begin
                        res_reg.status <= op_reg.err_code;
                    end
                    else
                    begin
                        unique case (op_reg.req.command)
                            CMD_PUBLISH:
                            begin
                                if (nid == '1)
                                begin
                                    res_reg.status <= ST_IDS_DONE;
                                end
                                else if (!cache_hit)
                                begin
                                    push_reg  <= 1'b0;
                                    rem_reg   <= '0;
                                    cnt_reg   <= 5'd31;
                                    state_reg <= S_MOD;
                                end
                                else
                                begin
                                    res_reg.event_id <= nid;
                                    next_id_reg[p]   <= nid + 1'b1;
                                    wslot_reg[p]     <= wslot_inc[SLOT_W-1:0];
                                end
                            end
                            CMD_SUBSCRIBE:
                            begin
                                filt_reg[si] <= {1'b1, op_reg.req.match_any,
                                                 op_reg.req.event_kind};
                                ptr_reg[si]  <= nid;
                                res_reg.read_pointer <= nid;
                            end
                            CMD_CONSUME:
                            begin
                                if (!filt[TYPE_W+1])
                                begin
                                    res_reg.status <= ST_NOT_SUBSCR;
                                end
                                else if (!cache_hit)
                                begin
                                    push_reg  <= 1'b0;
                                    rem_reg   <= '0;
                                    cnt_reg   <= 5'd31;
                                    state_reg <= S_MOD;
                                end
                                else if (cur_ptr >= nid)
                                begin
                                    res_reg.status       <= ST_NO_MATCH;
                                    res_reg.read_pointer <= cur_ptr;
                                end
                                else
                                begin
                                    push_reg  <= 1'b0;
                                    cur_reg   <= (cur_ptr < old) ? old : cur_ptr;
                                    over_reg  <= (cur_ptr < old);
                                    state_reg <= S_SLOT;
                                end
                            end
                            CMD_REWIND:
                            begin
                                if (!filt[TYPE_W+1])
                                begin
                                    res_reg.status <= ST_NOT_SUBSCR;
                                end
                                else
                                begin
                                    res_reg.read_pointer <= cur_ptr;
                                    if (op_reg.req.rewind_steps == '0)
                                    begin
                                        res_reg.status <= ST_BAD_STEPS;
                                    end
                                    else if ({16'd0, op_reg.req.rewind_steps} > cur_ptr)
                                    begin
                                        res_reg.status <= ST_NEG_TARGET;
                                    end
                                    else if (rw_target < old)
                                    begin
                                        res_reg.status <= ST_OVERWRITTEN;
                                    end
                                    else
                                    begin
                                        ptr_reg[si]          <= rw_target;
                                        res_reg.read_pointer <= rw_target;
                                    end
                                end
                            end
                            default:
                            begin
                                res_reg.status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    // One remainder bit per cycle, most significant id bit first.
                    rem_reg <= rem_nx;
                    if (cnt_reg == 5'd0)
                    begin
                        wslot_reg[p] <= rem_nx[SLOT_W-1:0];
                        ccap_reg[p]  <= cap_c;
                        cok_reg[p]   <= 1'b1;
                        state_reg    <= S_EXEC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_SLOT:
                begin
                    slot_reg  <= slot_calc[SLOT_W-1:0];
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (match || (cur_inc >= nid))
                    begin
                        ptr_reg[si]          <= cur_inc;
                        res_reg              <= '0;
                        res_reg.overrun      <= over_reg;
                        res_reg.read_pointer <= cur_inc;
                        push_reg             <= 1'b1;
                        state_reg            <= S_IDLE;
                        if (match)
                        begin
                            res_reg.event_id       <= cur_reg;
                            res_reg.event_kind_out <= rd_reg[TYPE_W+DATA_W-1:DATA_W];
                            res_reg.payload_out    <= rd_reg[DATA_W-1:0];
                        end
                        else
                        begin
                            res_reg.status <= ST_NO_MATCH;
                        end
                    end
                    else
                    begin
                        cur_reg   <= cur_inc;
                        slot_reg  <= slot_inc[SLOT_W-1:0];
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/mre_outq.sv -----
// Two-entry result queue between the back end and the result ports.
// Uses mre_pkg for the result type.
`timescale 1ns / 1ps
module mre_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  mre_pkg::result_t res_in,
    output logic             res_full,
    output logic             empty,
    input  logic             pop,
    output mre_pkg::result_t result
);
    import mre_pkg::*;

    result_t    q_mem [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign result   = q_mem[rd_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- design/multi_reader_event_ring_unit.sv -----
// Multi-reader event ring: four overwrite-on-full partitions, eight subscribers
// with their own pointers and type filters. One request is handled at a time.
// Error requests, subscribe, rewind and a consume with nothing left to scan are
// answered from the execute state; publish is too when the partition's write
// slot is known. Publish and consume first rebuild that slot once after reset
// or after a capacity change, by a bit-serial remainder of the next id. A
// consume that scans passes through the slot state, then reads and checks one
// event at a time until one matches or none are left, so its time grows with
// the data. Two-entry queues sit on both sides.
// Top level; depends on mre_pkg, mre_front, mre_back and mre_outq.
`timescale 1ns / 1ps
module multi_reader_event_ring_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  mre_pkg::request_t                 request,
    output logic                              empty,
    input  logic                              pop,
    output mre_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [mre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mre_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mre_pkg::*;

    logic [PARTS-1:0] part_en_reg;
    logic [SUBS-1:0]  sub_en_reg;
    logic [CAP_W-1:0] cap_reg [PARTS];
    cap_vec_t         cap_eff;
    op_t              op;
    logic             op_valid;
    logic             op_pop;
    logic             res_full;
    logic             res_push;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_en_reg <= '0;
            sub_en_reg  <= '0;
            for (int i = 0; i < PARTS; i++)
            begin
                cap_reg[i] <= CAP_W'(MAX_CAP);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PART_EN: part_en_reg <= cfg_data[PARTS-1:0];
                CFG_SUB_EN:  sub_en_reg  <= cfg_data[SUBS-1:0];
                CFG_CAP0:    cap_reg[0]  <= cfg_data;
                CFG_CAP1:    cap_reg[1]  <= cfg_data;
                CFG_CAP2:    cap_reg[2]  <= cfg_data;
                CFG_CAP3:    cap_reg[3]  <= cfg_data;
                default:     part_en_reg <= part_en_reg;
            endcase
        end
    end

    // A capacity of zero acts as one; anything above the ring size is clamped.
    always_comb
    begin
        for (int i = 0; i < PARTS; i++)
        begin
            if (cap_reg[i] == '0)
            begin
                cap_eff[i] = CAP_W'(1);
            end
            else if (cap_reg[i] > CAP_W'(MAX_CAP))
            begin
                cap_eff[i] = CAP_W'(MAX_CAP);
            end
            else
            begin
                cap_eff[i] = cap_reg[i];
            end
        end
    end

    mre_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .part_en  (part_en_reg),
        .sub_en   (sub_en_reg),
        .op       (op),
        .op_valid (op_valid),
        .op_pop   (op_pop)
    );

    mre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .op_valid (op_valid),
        .op_pop   (op_pop),
        .cap      (cap_eff),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res)
    );

    mre_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
